### rtl/lcr_pkg.sv
// Package for the load-cell converter serial reader.
// Holds the phase type, command and register codes, and the control structs.
// No dependencies.
package lcr_pkg;

	localparam int SHIFT_W = 24;
	localparam int SUM_W = 32;
	localparam int VALUE_W = 25;
	localparam int DIV_STEPS = 32;

	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_NET_READ = 3'd1;
	localparam logic [2:0] CMD_RAW_READ = 3'd2;
	localparam logic [2:0] CMD_POWER_DOWN = 3'd3;
	localparam logic [2:0] CMD_POWER_UP = 3'd4;

	localparam logic [1:0] REG_GAIN_PULSES = 2'd0;
	localparam logic [1:0] REG_HALF_PERIOD = 2'd1;
	localparam logic [1:0] REG_AVERAGE_COUNT = 2'd2;
	localparam logic [1:0] REG_OFFSET = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_WAIT = 3'd1,
		PH_HIGH = 3'd2,
		PH_LOW = 3'd3,
		PH_DIV = 3'd4
	} phase_t;

	typedef struct packed {
		logic       clr_sum;
		logic       clr_shift;
		logic       shift_en;
		logic       acc_en;
		logic       div_init;
		logic       div_step;
		logic       net;
		logic [7:0] divisor;
	} dp_cmd_t;

	typedef struct packed {
		logic sck;
		logic busy;
		logic sleep;
		logic done;
	} ctrl_stat_t;

endpackage

### rtl/lcr_ctrl.sv
// Sequencer for the serial reader: phase state machine, phase timer,
// pulse and conversion counters, divider step count.
// Depends on lcr_pkg.
module lcr_ctrl #(
	parameter int ADC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [2:0]          command,
	input  logic                dout_level,
	input  logic [1:0]          gain_pulses,
	input  logic [7:0]          half_period_ticks,
	input  logic [7:0]          average_count,
	output lcr_pkg::dp_cmd_t    dp_cmd,
	output lcr_pkg::ctrl_stat_t stat
);
	import lcr_pkg::*;

	phase_t     phase_q, phase_nxt;
	logic       clock_q, clock_nxt;
	logic       sleep_q, sleep_nxt;
	logic       net_q, net_nxt;
	logic [7:0] timer_q, timer_nxt;
	logic [4:0] pulse_q, pulse_nxt;
	logic [7:0] conv_q, conv_nxt;
	logic [5:0] dstep_q, dstep_nxt;

	logic [7:0] half;
	logic [7:0] avg_lim;
	logic [4:0] total_pulses;
	logic [7:0] timer_inc;
	logic [4:0] pulse_inc;
	logic [7:0] conv_inc;
	logic [5:0] dstep_inc;

	assign half = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
	assign avg_lim = (average_count == 8'd0) ? 8'd1 : average_count;
	assign total_pulses = 5'(ADC_BITS) + ((gain_pulses == 2'd0) ? 5'd1 : {3'd0, gain_pulses});
	assign timer_inc = timer_q + 8'd1;
	assign pulse_inc = pulse_q + 5'd1;
	assign conv_inc = conv_q + 8'd1;
	assign dstep_inc = dstep_q + 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			clock_q <= 1'b0;
			sleep_q <= 1'b0;
			net_q <= 1'b0;
			timer_q <= '0;
			pulse_q <= '0;
			conv_q <= '0;
			dstep_q <= '0;
		end else begin
			phase_q <= phase_nxt;
			clock_q <= clock_nxt;
			sleep_q <= sleep_nxt;
			net_q <= net_nxt;
			timer_q <= timer_nxt;
			pulse_q <= pulse_nxt;
			conv_q <= conv_nxt;
			dstep_q <= dstep_nxt;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		clock_nxt = clock_q;
		sleep_nxt = sleep_q;
		net_nxt = net_q;
		timer_nxt = timer_q;
		pulse_nxt = pulse_q;
		conv_nxt = conv_q;
		dstep_nxt = dstep_q;
		dp_cmd = '0;
		dp_cmd.net = net_q;
		dp_cmd.divisor = (conv_q == 8'd0) ? 8'd1 : conv_q;
		stat.done = 1'b0;
		if (step) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (!dout_level) begin
						clock_nxt = 1'b1;
						timer_nxt = '0;
						pulse_nxt = '0;
						dp_cmd.clr_shift = 1'b1;
						phase_nxt = PH_HIGH;
					end
				end
				PH_HIGH: begin
					timer_nxt = timer_inc;
					if (timer_inc >= half) begin
						dp_cmd.shift_en = (pulse_q < 5'(ADC_BITS));
						clock_nxt = 1'b0;
						timer_nxt = '0;
						phase_nxt = PH_LOW;
					end
				end
				PH_LOW: begin
					timer_nxt = timer_inc;
					if (timer_inc >= half) begin
						timer_nxt = '0;
						pulse_nxt = pulse_inc;
						if (pulse_inc >= total_pulses) begin
							dp_cmd.acc_en = 1'b1;
							conv_nxt = conv_inc;
							if (conv_inc >= avg_lim) begin
								dp_cmd.div_init = 1'b1;
								dstep_nxt = '0;
								phase_nxt = PH_DIV;
							end else begin
								phase_nxt = PH_WAIT;
							end
						end else begin
							clock_nxt = 1'b1;
							phase_nxt = PH_HIGH;
						end
					end
				end
				PH_DIV: begin
					dp_cmd.div_step = 1'b1;
					dstep_nxt = dstep_inc;
					if (dstep_inc >= 6'(DIV_STEPS)) begin
						stat.done = 1'b1;
						phase_nxt = PH_IDLE;
					end
				end
				default: begin
					phase_nxt = PH_IDLE;
					if ((command == CMD_NET_READ || command == CMD_RAW_READ) && !sleep_q) begin
						net_nxt = (command == CMD_NET_READ);
						dp_cmd.clr_sum = 1'b1;
						conv_nxt = '0;
						clock_nxt = 1'b0;
						phase_nxt = PH_WAIT;
					end else if (command == CMD_POWER_DOWN) begin
						sleep_nxt = 1'b1;
						clock_nxt = 1'b1;
					end else if (command == CMD_POWER_UP) begin
						sleep_nxt = 1'b0;
						clock_nxt = 1'b0;
					end
				end
			endcase
		end
		stat.sck = clock_nxt;
		stat.busy = (phase_nxt != PH_IDLE);
		stat.sleep = sleep_nxt;
	end

endmodule

### rtl/lcr_datapath.sv
// Datapath of the serial reader: sample shifter, running sum,
// restoring divider one bit per step, and result forming.
// Depends on lcr_pkg.
module lcr_datapath #(
	parameter int ADC_BITS = 24
) (
	input  logic                                clk,
	input  lcr_pkg::dp_cmd_t                    dp_cmd,
	input  logic                                dout_level,
	input  logic [23:0]                         offset,
	output logic signed [lcr_pkg::VALUE_W-1:0]  result_value
);
	import lcr_pkg::*;

	logic [SHIFT_W-1:0] shift_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   quot_q;
	logic [7:0]         rem_q;

	logic [SUM_W-1:0]   sample_ext;
	logic [SUM_W-1:0]   sum_acc;
	logic [SUM_W-1:0]   quot_nxt;
	logic [7:0]         rem_nxt;
	logic [8:0]         rem_sh;
	logic [VALUE_W-1:0] avg;
	logic [VALUE_W-1:0] off_ext;

	assign sample_ext = {{(SUM_W - ADC_BITS){shift_q[ADC_BITS-1]}}, shift_q[ADC_BITS-1:0]};
	assign sum_acc = sum_q + sample_ext;

	always_comb begin
		rem_sh = {rem_q, quot_q[SUM_W-1]};
		if (rem_sh >= {1'b0, dp_cmd.divisor}) begin
			rem_nxt = 8'(rem_sh - {1'b0, dp_cmd.divisor});
			quot_nxt = {quot_q[SUM_W-2:0], 1'b1};
		end else begin
			rem_nxt = rem_sh[7:0];
			quot_nxt = {quot_q[SUM_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.clr_shift) begin
			shift_q <= '0;
		end else if (dp_cmd.shift_en) begin
			shift_q <= {shift_q[SHIFT_W-2:0], dout_level};
		end
		if (dp_cmd.clr_sum) begin
			sum_q <= '0;
		end else if (dp_cmd.acc_en) begin
			sum_q <= sum_acc;
		end
		if (dp_cmd.div_init) begin
			rem_q <= '0;
			quot_q <= sum_acc[SUM_W-1] ? (~sum_acc + 32'd1) : sum_acc;
		end else if (dp_cmd.div_step) begin
			rem_q <= rem_nxt;
			quot_q <= quot_nxt;
		end
	end

	// The result is formed from the quotient after the final divider step.
	assign avg = sum_q[SUM_W-1] ? (~quot_nxt[VALUE_W-1:0] + 25'd1) : quot_nxt[VALUE_W-1:0];
	assign off_ext = dp_cmd.net ? {offset[23], offset} : '0;
	assign result_value = avg - off_ext;

endmodule

### rtl/load_cell_adc_serial_reader.sv
// Top level of the load-cell converter serial reader.
// Holds the configuration registers and the output register; instantiates
// lcr_ctrl and lcr_datapath. Depends on lcr_pkg.
//
//  Channel  Direction  Contents
//  s_*      in         one clock tick: command and sampled data line
//  m_*      out        one status item per input item, with result when done
//  cfg_*    in         register writes, no read-back
//
// Every input item is one tick of the serial clock sequencer and yields one
// output item; an item enters each cycle while the output register is free
// or being taken. The averaging divider takes 32 items per read, one
// quotient bit per item. Reset is asynchronous and clears all control
// state. A stall on the output holds the result and blocks the input.
module load_cell_adc_serial_reader #(
	parameter int ADC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [2:0] command, [3] dout_level, [7:4] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [0] sck_level, [1] busy_res, [2] adc_ready,
	                              // [3] powered_down, [4] result_valid,
	                              // [29:5] result_value, [31:30] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_data
);
	import lcr_pkg::*;

	logic [1:0]  gain_q;
	logic [7:0]  half_q;
	logic [7:0]  avg_q;
	logic [23:0] offset_q;

	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic               step;
	logic [2:0]         command;
	logic               dout_level;
	dp_cmd_t            dp_cmd;
	ctrl_stat_t         stat;
	logic [VALUE_W-1:0] result_value;
	logic [31:0]        out_word;

	assign command = s_tdata[2:0];
	assign dout_level = s_tdata[3];
	assign s_tready = !out_valid_q || m_tready;
	assign step = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 2'd1;
			half_q <= 8'd1;
			avg_q <= 8'd1;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GAIN_PULSES: gain_q <= cfg_data[1:0];
				REG_HALF_PERIOD: half_q <= cfg_data[7:0];
				REG_AVERAGE_COUNT: avg_q <= cfg_data[7:0];
				REG_OFFSET: offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lcr_ctrl #(
		.ADC_BITS(ADC_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.command(command),
		.dout_level(dout_level),
		.gain_pulses(gain_q),
		.half_period_ticks(half_q),
		.average_count(avg_q),
		.dp_cmd(dp_cmd),
		.stat(stat)
	);

	lcr_datapath #(
		.ADC_BITS(ADC_BITS)
	) u_datapath (
		.clk(clk),
		.dp_cmd(dp_cmd),
		.dout_level(dout_level),
		.offset(offset_q),
		.result_value(result_value)
	);

	assign out_word = {2'b00,
		stat.done ? result_value : {VALUE_W{1'b0}},
		stat.done,
		stat.sleep,
		!dout_level && !stat.sleep,
		stat.busy,
		stat.sck};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= out_word;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

### rtl/lcr_checker.sv
// Port-level checks for the load-cell converter serial reader.
// Bound to load_cell_adc_serial_reader; no package dependency.
module lcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[29:5] == 25'd0)
		else $error("result value set without result valid");

	a_sleep_clock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[0] && !m_tdata[2])
		else $error("powered down without clock held high or with ready set");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[1] && !m_tdata[0])
		else $error("result delivered while still busy or clock high");

endmodule

bind load_cell_adc_serial_reader lcr_checker u_lcr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

### tb/tb_load_cell_adc_serial_reader.sv
`timescale 1ns / 1ps
// Self-checking testbench for load_cell_adc_serial_reader: a tick-level model predicts every
// status item, driven by a converter-like stimulus with random stalls on both streams.
// Depends on lcr_pkg and the RTL of the reader.
module tb_load_cell_adc_serial_reader;
	import lcr_pkg::*;

	localparam int ADC_BITS = SHIFT_W;
	localparam int LIMIT = 1000000;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               valid;
		logic               pdown;
		logic               ready;
		logic               busy;
		logic               sck;
	} status_t;

	class reader_model;
		logic [1:0]        gain;
		logic [7:0]        half_ticks;
		logic [7:0]        avg_count;
		logic [23:0]       offset;
		phase_t            phase;
		logic              sck;
		logic [7:0]        timer;
		logic [4:0]        pulses;
		logic [23:0]       shift;
		logic [SUM_W-1:0]  sum;
		logic [7:0]        convs;
		logic              net_read;
		logic              sleep;
		logic [31:0]       rem;
		logic [31:0]       quo;
		logic [5:0]        step;
		status_t           expected_status[$];
		int                mismatches;
		int                readings;
		int                ticks;

		function new();
			gain = 2'd1;
			half_ticks = 8'd1;
			avg_count = 8'd1;
			offset = '0;
			phase = PH_IDLE;
			sck = 1'b0;
			timer = '0;
			pulses = '0;
			shift = '0;
			sum = '0;
			convs = '0;
			net_read = 1'b0;
			sleep = 1'b0;
			rem = '0;
			quo = '0;
			step = '0;
			mismatches = 0;
			readings = 0;
			ticks = 0;
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		function void write_reg(logic [1:0] idx, logic [23:0] val);
			case (idx)
				REG_GAIN_PULSES: gain = val[1:0];
				REG_HALF_PERIOD: half_ticks = val[7:0];
				REG_AVERAGE_COUNT: avg_count = val[7:0];
				REG_OFFSET: offset = val;
			endcase
		endfunction

		function void note_tick(logic [2:0] cmd, logic dout);
			logic [7:0]  half;
			logic [7:0]  avg_lim;
			logic [4:0]  total;
			logic [31:0] divisor;
			longint      avg;
			status_t     st;
			half = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
			avg_lim = (avg_count == 8'd0) ? 8'd1 : avg_count;
			total = 5'(ADC_BITS) + ((gain == 2'd0) ? 5'd1 : 5'(gain));
			st = '0;
			case (phase)
				PH_WAIT: begin
					if (!dout) begin
						sck = 1'b1;
						timer = '0;
						pulses = '0;
						shift = '0;
						phase = PH_HIGH;
					end
				end
				PH_HIGH: begin
					timer = timer + 8'd1;
					if (timer >= half) begin
						if (pulses < ADC_BITS)
							shift = {shift[22:0], dout};
						sck = 1'b0;
						timer = '0;
						phase = PH_LOW;
					end
				end
				PH_LOW: begin
					timer = timer + 8'd1;
					if (timer >= half) begin
						timer = '0;
						pulses = pulses + 5'd1;
						if (pulses >= total) begin
							sum = sum + {{(SUM_W-24){shift[23]}}, shift};
							convs = convs + 8'd1;
							if (convs >= avg_lim) begin
								rem = '0;
								quo = sum[SUM_W-1] ? 32'd0 - sum : sum;
								step = '0;
								phase = PH_DIV;
							end else begin
								phase = PH_WAIT;
							end
						end else begin
							sck = 1'b1;
							phase = PH_HIGH;
						end
					end
				end
				PH_DIV: begin
					divisor = (convs == 8'd0) ? 32'd1 : 32'(convs);
					rem = {rem[30:0], quo[31]};
					quo = {quo[30:0], 1'b0};
					if (rem >= divisor) begin
						rem = rem - divisor;
						quo[0] = 1'b1;
					end
					step = step + 6'd1;
					if (step >= DIV_STEPS) begin
						avg = longint'(quo);
						if (sum[SUM_W-1])
							avg = -avg;
						if (net_read)
							avg = avg - longint'($signed(offset));
						st.valid = 1'b1;
						st.value = avg[VALUE_W-1:0];
						phase = PH_IDLE;
						readings++;
					end
				end
				default: begin
					phase = PH_IDLE;
					if ((cmd == CMD_NET_READ || cmd == CMD_RAW_READ) && !sleep) begin
						net_read = (cmd == CMD_NET_READ);
						sum = '0;
						convs = '0;
						sck = 1'b0;
						phase = PH_WAIT;
					end else if (cmd == CMD_POWER_DOWN) begin
						sleep = 1'b1;
						sck = 1'b1;
					end else if (cmd == CMD_POWER_UP) begin
						sleep = 1'b0;
						sck = 1'b0;
					end
				end
			endcase
			st.sck = sck;
			st.busy = (phase != PH_IDLE);
			st.ready = !dout && !sleep;
			st.pdown = sleep;
			expected_status.push_back(st);
			ticks++;
		endfunction

		function void check_status(logic [31:0] got);
			status_t want;
			status_t seen;
			seen = got[29:0];
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("status item %h arrived with nothing pending", got);
				return;
			end
			want = expected_status.pop_front();
			if (want.sck !== seen.sck || want.busy !== seen.busy || want.ready !== seen.ready ||
			    want.pdown !== seen.pdown || want.valid !== seen.valid ||
			    want.value !== seen.value) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("expected sck %b busy %b ready %b pdown %b valid %b value %0d",
						want.sck, want.busy, want.ready, want.pdown, want.valid,
						$signed(want.value));
					$display("     got sck %b busy %b ready %b pdown %b valid %b value %0d",
						seen.sck, seen.busy, seen.ready, seen.pdown, seen.valid,
						$signed(seen.value));
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [2:0] command, [3] dout_level, [7:4] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [0] sck_level, [1] busy_res, [2] adc_ready, [3] powered_down,
	                        // [4] result_valid, [29:5] result_value, [31:30] zero
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [23:0] cfg_data;

	reader_model model_h;
	logic        gaps_on;
	logic [23:0] conv_word;
	int          cycle_count = 0;
	int          cfg_writes = 0;

	load_cell_adc_serial_reader uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("load_cell_adc_serial_reader: mismatch");
			$finish;
		end
	end

	initial begin
		int n;
		do @(posedge clk); while (!arst_n);
		forever begin
			n = gaps_on ? $urandom_range(0, 4) : 0;
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			model_h.check_status(m_tdata);
		end
	end

	// Acts like the converter: data goes low soon after a read starts, then the
	// chosen word is presented bit by bit while the clock is high.
	function automatic void pick_item(output logic [2:0] cmd, output logic dout);
		int r;
		int idx;
		r = $urandom_range(0, 99);
		if (model_h.phase == PH_IDLE) begin
			if (model_h.sleep)
				cmd = (r < 50) ? CMD_POWER_UP : 3'($urandom_range(0, 7));
			else if (r < 70)
				cmd = ($urandom_range(0, 9) < 6) ? CMD_NET_READ : CMD_RAW_READ;
			else if (r < 76)
				cmd = CMD_POWER_DOWN;
			else
				cmd = 3'($urandom_range(0, 7));
		end else begin
			cmd = 3'($urandom_range(0, 7));
		end
		idx = ADC_BITS - 1 - int'(model_h.pulses);
		if ($urandom_range(0, 99) < 8) begin
			dout = 1'($urandom_range(0, 1));
		end else if (model_h.phase == PH_WAIT) begin
			dout = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 7))
				0: conv_word = 24'h000000;
				1: conv_word = 24'h7FFFFF;
				2: conv_word = 24'h800000;
				3: conv_word = 24'hFFFFFF;
				default: conv_word = 24'($urandom);
			endcase
		end else if (model_h.phase == PH_HIGH && idx >= 0) begin
			dout = conv_word[idx];
		end else begin
			dout = 1'($urandom_range(0, 1));
		end
	endfunction

	task automatic send_item(logic [2:0] cmd, logic dout);
		int n;
		n = gaps_on ? $urandom_range(0, 4) : 0;
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, dout, cmd};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		model_h.note_tick(cmd, dout);
	endtask

	task automatic run_ticks(int n, int reads_wanted);
		logic [2:0] c;
		logic       d;
		int         goal;
		int         k;
		goal = model_h.readings + reads_wanted;
		k = 0;
		while (k < n || model_h.readings < goal) begin
			pick_item(c, d);
			send_item(c, d);
			k++;
		end
	endtask

	task automatic finish_read();
		logic [2:0] c;
		logic       d;
		while (model_h.phase != PH_IDLE) begin
			pick_item(c, d);
			send_item(c, d);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (model_h.pending() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		model_h.write_reg(idx, val);
		cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [1:0] g, logic [7:0] h, logic [7:0] a, logic [23:0] o);
		cfg_write(REG_GAIN_PULSES, 24'(g));
		cfg_write(REG_HALF_PERIOD, 24'(h));
		cfg_write(REG_AVERAGE_COUNT, 24'(a));
		cfg_write(REG_OFFSET, o);
	endtask

	initial begin
		int n;
		int r;
		int random_ticks;
		model_h = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		gaps_on = 1'b1;
		conv_word = '0;
		random_ticks = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle commands, unknown codes, reads refused while asleep, and commands
		// thrown at a busy sequencer.
		send_item(CMD_NONE, 1'b1);
		send_item(3'd5, 1'b0);
		send_item(3'd6, 1'b1);
		send_item(3'd7, 1'b0);
		send_item(CMD_POWER_DOWN, 1'b1);
		send_item(CMD_NET_READ, 1'b0);
		send_item(CMD_RAW_READ, 1'b0);
		send_item(CMD_POWER_DOWN, 1'b0);
		send_item(CMD_POWER_UP, 1'b1);
		send_item(CMD_POWER_UP, 1'b0);
		send_item(CMD_NET_READ, 1'b1);
		send_item(CMD_POWER_DOWN, 1'b1);
		send_item(CMD_RAW_READ, 1'b1);
		send_item(CMD_NONE, 1'b1);
		send_item(CMD_NONE, 1'b0);
		run_ticks(0, 2);

		drain();
		set_regs(2'd0, 8'd0, 8'd0, 24'h800000);
		run_ticks(100, 3);

		// Longest clock phases, then register changes while a read is running.
		finish_read();
		drain();
		gaps_on = 1'b0;
		set_regs(2'd3, 8'd255, 8'd1, 24'h7FFFFF);
		run_ticks(520, 0);

		drain();
		set_regs(2'd2, 8'd1, 8'd255, 24'h800000);
		run_ticks(200, 0);
		drain();
		cfg_write(REG_AVERAGE_COUNT, 24'd2);
		finish_read();

		while (random_ticks < 600) begin
			drain();
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1))
				cfg_write(REG_GAIN_PULSES, 24'($urandom_range(0, 3)));
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 99);
				n = (r < 70) ? $urandom_range(1, 3) : (r < 85) ? 0 : $urandom_range(4, 8);
				cfg_write(REG_HALF_PERIOD, 24'(n));
			end
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 99);
				n = (r < 60) ? $urandom_range(1, 3) : (r < 80) ? 0 : $urandom_range(4, 6);
				cfg_write(REG_AVERAGE_COUNT, 24'(n));
			end
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 9);
				cfg_write(REG_OFFSET, (r == 0) ? 24'h800000 : (r == 1) ? 24'h7FFFFF :
					24'($urandom));
			end
			n = $urandom_range(40, 250);
			run_ticks(n, 0);
			random_ticks += n;
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Ran %0d ticks in %0d cycles, %0d averaged readings, %0d register writes.",
			model_h.ticks, cycle_count, model_h.readings, cfg_writes);
		$display("Included power cycling, ignored commands, zero and maximal register values.");
		if (model_h.mismatches == 0 && model_h.pending() == 0)
			$display("load_cell_adc_serial_reader: match");
		else
			$display("load_cell_adc_serial_reader: mismatch");
		$finish;
	end
endmodule
